// ----- src/weighted_random_selector_core_assert.svh -----
// Assertion macros shared by the weighted random selector RTL.
`ifndef WEIGHTED_RANDOM_SELECTOR_CORE_ASSERT_SVH
`define WEIGHTED_RANDOM_SELECTOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WRS_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("weighted_random_selector_core: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WRS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("weighted_random_selector_core: assertion failed");

`endif

// ----- src/wrs_pkg.sv -----
// Shared constants and types for the weighted random selector.
package wrs_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int SLOT_BITS   = 4;
    localparam int FRAC_BITS   = 16;
    localparam int COUNT_BITS  = 5;
    localparam int SUM_BITS    = WEIGHT_BITS + $clog2(SLOT_COUNT);
    localparam int PROD_BITS   = SUM_BITS + FRAC_BITS;
    localparam int CYC_BITS    = $clog2(SLOT_COUNT + 1);

    typedef struct packed {
        logic scan;
        logic wr_en;
        logic in_use;
    } cell_ctl_t;

    typedef struct packed {
        logic [SUM_BITS-1:0]  acc;
        logic                 hit;
        logic [SLOT_BITS-1:0] idx;
    } link_t;

endpackage

// ----- src/wrs_cell.sv -----
// One slot cell: holds a weight and extends the running sum passed along the row.
module wrs_cell
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  wrs_pkg::cell_ctl_t              ctl,
    input  logic [wrs_pkg::SLOT_BITS-1:0]   cell_id,
    input  logic [wrs_pkg::WEIGHT_BITS-1:0] wr_weight,
    input  logic [wrs_pkg::SUM_BITS-1:0]    target,
    input  wrs_pkg::link_t                  link_in,
    output wrs_pkg::link_t                  link_out
);

    logic [wrs_pkg::WEIGHT_BITS-1:0] weight_reg;
    logic [wrs_pkg::WEIGHT_BITS-1:0] weight_next;
    wrs_pkg::link_t                  link_reg;
    wrs_pkg::link_t                  link_next;
    logic [wrs_pkg::SUM_BITS-1:0]    acc_sum;

    always_comb
    begin
        weight_next = ctl.wr_en ? wr_weight : weight_reg;
    end

    always_comb
    begin
        acc_sum = link_in.acc
                + (ctl.in_use ? wrs_pkg::SUM_BITS'(weight_reg) : '0);
        link_next     = link_in;
        link_next.acc = acc_sum;
        if (ctl.scan && !link_in.hit && ctl.in_use && (acc_sum > target))
        begin
            link_next.hit = 1'b1;
            link_next.idx = cell_id;
        end
        if (!ctl.scan)
        begin
            link_next.hit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
        end
        else
        begin
            weight_reg <= weight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        link_reg <= link_next;
    end

    assign link_out = link_reg;

endmodule

// ----- src/weighted_random_selector_core.sv -----
// Top level of the weighted random selector: control, cell row and result register.
// A write beat is accepted only while the core is idle. A select beat runs one row pass to form
// the total, the multiply state, one scan pass and the load of the result register, after which
// its result is valid. The next beat is accepted once the core is back in idle, so selects also
// wait while a previous result that is still stalled holds up the load.
// Reset clears all slot weights, the slot count register and all control state.
module weighted_random_selector_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wrs_pkg::COUNT_BITS-1:0]  cfg_data,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic                            mode,
    input  logic [wrs_pkg::SLOT_BITS-1:0]   slot,
    input  logic [15:0]                     weight,
    input  logic [wrs_pkg::FRAC_BITS-1:0]   random_fraction,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            found,
    output logic [wrs_pkg::SLOT_BITS-1:0]   chosen_slot
);

    typedef enum logic [4:0]
    {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_MUL  = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    localparam logic MODE_WRITE = 1'b0;

    state_t                              state_reg;
    state_t                              state_next;
    logic [wrs_pkg::CYC_BITS-1:0]        cyc_reg;
    logic [wrs_pkg::CYC_BITS-1:0]        cyc_next;
    logic [wrs_pkg::COUNT_BITS-1:0]      count_reg;
    logic [wrs_pkg::COUNT_BITS-1:0]      count_next;
    logic [wrs_pkg::FRAC_BITS-1:0]       frac_reg;
    logic [wrs_pkg::FRAC_BITS-1:0]       frac_next;
    logic [wrs_pkg::PROD_BITS-1:0]       prod_reg;
    logic [wrs_pkg::PROD_BITS-1:0]       prod_next;
    logic                                zero_reg;
    logic                                zero_next;
    logic                                rsp_valid_reg;
    logic                                rsp_valid_next;
    logic                                found_reg;
    logic                                found_next;
    logic [wrs_pkg::SLOT_BITS-1:0]       chosen_reg;
    logic [wrs_pkg::SLOT_BITS-1:0]       chosen_next;

    logic                                req_accept;
    logic                                wr_accept;
    logic                                load_rsp;
    logic                                last_cyc;
    logic [wrs_pkg::COUNT_BITS-1:0]      count_sat;
    logic [wrs_pkg::WEIGHT_BITS-1:0]     wr_weight;
    logic [wrs_pkg::SUM_BITS-1:0]        target;
    wrs_pkg::link_t                      links [wrs_pkg::SLOT_COUNT+1];
    wrs_pkg::cell_ctl_t                  cell_ctl [wrs_pkg::SLOT_COUNT];

    assign cfg_ready  = 1'b1;
    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign wr_accept  = req_accept && (mode == MODE_WRITE);
    assign last_cyc   = (cyc_reg == wrs_pkg::CYC_BITS'(wrs_pkg::SLOT_COUNT - 1));
    assign load_rsp   = (state_reg == S_DONE) && !(rsp_valid_reg && rsp_stall);
    assign wr_weight  = wrs_pkg::WEIGHT_BITS'(weight);
    assign target     = prod_reg[wrs_pkg::FRAC_BITS +: wrs_pkg::SUM_BITS];

    assign count_sat = (count_reg > wrs_pkg::COUNT_BITS'(wrs_pkg::SLOT_COUNT))
                     ? wrs_pkg::COUNT_BITS'(wrs_pkg::SLOT_COUNT) : count_reg;

    assign links[0] = '0;

    for (genvar i = 0; i < wrs_pkg::SLOT_COUNT; i++)
    begin : g_cell
        always_comb
        begin
            cell_ctl[i].scan   = (state_reg == S_SCAN) || (state_reg == S_DONE);
            cell_ctl[i].wr_en  = wr_accept && (int'(slot) == i);
            cell_ctl[i].in_use = (int'(count_sat) > i);
        end

        wrs_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl[i]),
            .cell_id   (wrs_pkg::SLOT_BITS'(i)),
            .wr_weight (wr_weight),
            .target    (target),
            .link_in   (links[i]),
            .link_out  (links[i+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        cyc_next   = cyc_reg + 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                cyc_next = '0;
                if (req_accept && (mode != MODE_WRITE))
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (last_cyc)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cyc_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (last_cyc)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cyc_next = '0;
                if (load_rsp)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                cyc_next   = '0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = (cfg_valid && cfg_ready) ? cfg_data : count_reg;
        frac_next  = req_accept ? random_fraction : frac_reg;
        prod_next  = prod_reg;
        zero_next  = zero_reg;
        if (state_reg == S_MUL)
        begin
            prod_next = wrs_pkg::PROD_BITS'(frac_reg)
                      * wrs_pkg::PROD_BITS'(links[wrs_pkg::SLOT_COUNT].acc);
            zero_next = (links[wrs_pkg::SLOT_COUNT].acc == '0);
        end
        rsp_valid_next = (rsp_valid_reg && rsp_stall) || load_rsp;
        found_next     = found_reg;
        chosen_next    = chosen_reg;
        if (load_rsp)
        begin
            found_next  = !zero_reg && links[wrs_pkg::SLOT_COUNT].hit;
            chosen_next = found_next ? links[wrs_pkg::SLOT_COUNT].idx : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cyc_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cyc_reg       <= cyc_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg   <= frac_next;
        prod_reg   <= prod_next;
        zero_reg   <= zero_next;
        found_reg  <= found_next;
        chosen_reg <= chosen_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign found       = found_reg;
    assign chosen_slot = chosen_reg;

`include "weighted_random_selector_core_assert.svh"

    `WRS_ASSERT_IMPLY(a_state_onehot, 1'b1, $onehot(state_reg))
    `WRS_ASSERT_IMPLY(a_not_found_zero, rsp_valid && !found, chosen_slot == '0)
    `WRS_ASSERT_IMPLY(a_found_in_use, rsp_valid && found, {1'b0, chosen_slot} < count_sat)
    `WRS_ASSERT_NEXT(a_done_loads, state_reg == S_DONE && !(rsp_valid && rsp_stall),
                     rsp_valid && state_reg == S_IDLE)

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for weighted_random_selector_core with a queued driver and a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wrs_pkg::*;

    localparam logic MODE_WRITE   = 1'b0;
    localparam logic MODE_SELECT  = 1'b1;
    localparam int   SCAN_LATENCY = 2 * SLOT_COUNT + 3;
    localparam int   DRAIN_WAIT   = SCAN_LATENCY + 8;
    localparam int   PHASE_BEATS  = 205;

    typedef struct packed {
        logic                 mode;
        logic [SLOT_BITS-1:0] slot;
        logic [15:0]          weight;
        logic [FRAC_BITS-1:0] frac;
        logic                 drain;
    } sel_beat_t;

    typedef struct packed {
        logic                 found;
        logic [SLOT_BITS-1:0] slot;
    } pick_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [COUNT_BITS-1:0] cfg_data;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic                  mode = 1'b0;
    logic [SLOT_BITS-1:0]  slot = '0;
    logic [15:0]           weight = '0;
    logic [FRAC_BITS-1:0]  random_fraction = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    logic                  found;
    logic [SLOT_BITS-1:0]  chosen_slot;

    sel_beat_t             beat_q[$];
    sel_beat_t             next_beat;
    pick_t                 pick_q[$];
    pick_t                 want;
    logic [15:0]           weight_model[SLOT_COUNT];
    logic [COUNT_BITS-1:0] count_model;
    int                    pending_cnt = 0;
    int                    err_cnt = 0;
    int                    send_idle_pct = 38;
    int                    recv_idle_pct = 66;
    bit                    pushed;
    bit                    popped;

    weighted_random_selector_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .mode            (mode),
        .slot            (slot),
        .weight          (weight),
        .random_fraction (random_fraction),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .found           (found),
        .chosen_slot     (chosen_slot)
    );

    always #5 clk = ~clk;

    function automatic pick_t predict_pick(logic [FRAC_BITS-1:0] frac);
        int                   n;
        int                   i;
        logic [SUM_BITS-1:0]  total;
        logic [SUM_BITS-1:0]  running;
        logic [PROD_BITS-1:0] target;
        pick_t                r;
        n = (count_model > SLOT_COUNT) ? SLOT_COUNT : int'(count_model);
        r = '0;
        total = '0;
        for (i = 0; i < n; i++)
            total += weight_model[i];
        if (n == 0 || total == 0)
            return r;
        target = (PROD_BITS'(frac) * PROD_BITS'(total)) >> FRAC_BITS;
        running = '0;
        for (i = 0; i < n; i++)
        begin
            running += weight_model[i];
            if (PROD_BITS'(running) > target)
            begin
                r.found = 1'b1;
                r.slot  = SLOT_BITS'(i);
                return r;
            end
        end
        return r;
    endfunction

    function automatic sel_beat_t write_beat(int unsigned s, int unsigned w);
        sel_beat_t b;
        b.mode   = MODE_WRITE;
        b.slot   = SLOT_BITS'(s);
        b.weight = 16'(w);
        b.frac   = FRAC_BITS'($urandom);
        b.drain  = 1'b0;
        return b;
    endfunction

    function automatic sel_beat_t select_beat(int unsigned f);
        sel_beat_t b;
        b.mode   = MODE_SELECT;
        b.slot   = SLOT_BITS'($urandom);
        b.weight = 16'($urandom);
        b.frac   = FRAC_BITS'(f);
        b.drain  = 1'b0;
        return b;
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (beat_q.size() != 0 || req_valid || pending_cnt != 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_count(logic [COUNT_BITS-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid       <= 1'b0;
            mode            <= MODE_WRITE;
            slot            <= '0;
            weight          <= '0;
            random_fraction <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                (!beat_q[0].drain ||
                 (pending_cnt == 0 && !(req_valid && mode == MODE_SELECT))))
            begin
                next_beat       = beat_q.pop_front();
                req_valid       <= 1'b1;
                mode            <= next_beat.mode;
                slot            <= next_beat.slot;
                weight          <= next_beat.weight;
                random_fraction <= next_beat.frac;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            pushed = 1'b0;
            popped = 1'b0;
            if (cfg_valid && cfg_ready)
                count_model = cfg_data;
            if (req_valid && !req_stall)
            begin
                if (mode == MODE_WRITE)
                    weight_model[slot] = weight;
                else
                begin
                    pick_q.push_back(predict_pick(random_fraction));
                    pushed = 1'b1;
                end
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (pick_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result beat: found=%0d chosen_slot=%0d",
                                 found, chosen_slot);
                end
                else
                begin
                    want   = pick_q.pop_front();
                    popped = 1'b1;
                    if (found !== want.found || chosen_slot !== want.slot)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: expected found=%0d slot=%0d, got found=%0d slot=%0d",
                                     want.found, want.slot, found, chosen_slot);
                    end
                end
            end
            pending_cnt <= pending_cnt + int'(pushed) - int'(popped);
        end
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int        plan[9];
        int        p;
        int        k;
        int        pick;
        sel_beat_t b;
        plan = '{16, 5, 31, 1, 12, 0, 16, 9, 20};
        for (k = 0; k < SLOT_COUNT; k++)
            weight_model[k] = '0;
        count_model = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // No slots in use right after reset.
        @(negedge clk);
        beat_q.push_back(select_beat(16'hFFFF));
        wait_idle();
        write_count(5'd16);
        @(negedge clk);
        beat_q.push_back(select_beat(0));
        beat_q.push_back(write_beat(0, 16'hFFFF));
        beat_q.push_back(write_beat(15, 16'hFFFF));
        beat_q.push_back(write_beat(7, 1));
        beat_q.push_back(select_beat(0));
        beat_q.push_back(select_beat(16'h7FFF));
        beat_q.push_back(select_beat(16'h8000));
        beat_q.push_back(select_beat(16'hFFFF));
        beat_q.push_back(write_beat(0, 0));
        b = select_beat(0);
        b.drain = 1'b1;
        beat_q.push_back(b);
        beat_q.push_back(select_beat(16'hFFFF));
        wait_idle();
        write_count(5'd31);
        @(negedge clk);
        beat_q.push_back(select_beat(16'hFFFF));
        beat_q.push_back(select_beat(0));
        wait_idle();
        write_count(5'd1);
        @(negedge clk);
        beat_q.push_back(select_beat(16'h1234));
        beat_q.push_back(write_beat(0, 1));
        beat_q.push_back(select_beat(16'hFFFF));
        wait_idle();

        for (p = 0; p < 9; p++)
        begin
            if (p < 3)
            begin
                send_idle_pct = 38;
                recv_idle_pct = 66;
            end
            else if (p < 6)
            begin
                send_idle_pct = 66;
                recv_idle_pct = 38;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_count(COUNT_BITS'(plan[p]));
            @(negedge clk);
            for (k = 0; k < PHASE_BEATS; k++)
            begin
                if ($urandom_range(99) < 50)
                begin
                    pick = $urandom_range(9);
                    if (pick < 2)
                        b = write_beat($urandom_range(15), 0);
                    else if (pick == 2)
                        b = write_beat($urandom_range(15), 16'hFFFF);
                    else if (pick < 6)
                        b = write_beat($urandom_range(15), $urandom_range(255));
                    else
                        b = write_beat($urandom_range(15), $urandom);
                end
                else
                begin
                    pick = $urandom_range(9);
                    if (pick == 0)
                        b = select_beat(0);
                    else if (pick == 1)
                        b = select_beat(16'hFFFF);
                    else
                        b = select_beat($urandom);
                end
                b.drain = ($urandom_range(99) < 2);
                beat_q.push_back(b);
            end
            wait_idle();
        end

        if (err_cnt == 0 && pick_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
